>>> src/bdq_pkg.sv
// Shared types and codes for the bounded deque with search.
package bdq_pkg;

    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 32;

    localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH     = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
        logic pop_back;
        logic search;
    } t_cell_ctl;

endpackage

>>> src/bdq_cell.sv
// One storage cell of the deque chain with its local key compare.
module bdq_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bdq_pkg::t_cell_ctl                i_ctl,
    input  logic signed [bdq_pkg::DATA_W-1:0] i_value,
    input  logic signed [bdq_pkg::DATA_W-1:0] i_prev_data,
    input  logic                              i_prev_valid,
    input  logic signed [bdq_pkg::DATA_W-1:0] i_next_data,
    input  logic                              i_next_valid,
    output logic signed [bdq_pkg::DATA_W-1:0] o_data,
    output logic                              o_valid,
    output logic                              o_hit
);

    logic signed [bdq_pkg::DATA_W-1:0] r_data;
    logic signed [bdq_pkg::DATA_W-1:0] n_data;
    logic                              r_valid;
    logic                              n_valid;
    logic                              r_hit;

    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        if (i_ctl.push_front) begin
            n_data  = i_prev_data;
            n_valid = i_prev_valid;
        end else if (i_ctl.push_back) begin
            if (!r_valid && i_prev_valid) begin
                n_data  = i_value;
                n_valid = 1'b1;
            end
        end else if (i_ctl.pop_front) begin
            n_data  = i_next_data;
            n_valid = i_next_valid;
        end else if (i_ctl.pop_back) begin
            if (r_valid && !i_next_valid) begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (i_ctl.search) begin
            r_hit <= r_valid && (r_data == i_value);
        end
    end

    assign o_data  = r_data;
    assign o_valid = r_valid;
    assign o_hit   = r_hit;

endmodule

>>> src/bounded_deque_with_search.sv
// Top level of the bounded deque: cell chain, occupancy count and result stages.
//
//  channel | handshake           | fields
//  --------+---------------------+-----------------------------
//  input   | i_valid / o_ready   | i_func, i_value
//  output  | o_valid / i_ready   | o_found, o_status, o_count
//
// One word is accepted per cycle when the output side keeps up.
// A result passes the pipeline stage, then the output stage: the cells update
// and compare as its word is accepted, the hit flags are combined as it moves on.
// Synchronous active-low reset empties the deque and both result stages.
// A stalled output holds its result and backs up into the input ready.
module bounded_deque_with_search #(
    parameter int DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [bdq_pkg::FUNC_W-1:0]          i_func,
    input  logic signed [bdq_pkg::DATA_W-1:0]   i_value,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_found,
    output logic [bdq_pkg::STATUS_W-1:0]        o_status,
    output logic [$clog2(DEPTH+1)-1:0]          o_count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);

    logic signed [bdq_pkg::DATA_W-1:0] w_data  [DEPTH];
    logic [DEPTH-1:0]                  w_valid;
    logic [DEPTH-1:0]                  w_hit;

    logic                       w_accept;
    logic                       w_p_move;
    logic                       w_full;
    logic                       w_empty;
    bdq_pkg::t_cell_ctl         w_ctl;

    logic [CW-1:0]                r_count;
    logic [CW-1:0]                n_count;
    logic [bdq_pkg::STATUS_W-1:0] n_status;

    logic                         r_p_valid;
    logic                         r_p_search;
    logic [bdq_pkg::STATUS_W-1:0] r_p_status;
    logic [CW-1:0]                r_p_count;

    logic                         r_o_valid;
    logic                         r_found;
    logic [bdq_pkg::STATUS_W-1:0] r_status;
    logic [CW-1:0]                r_o_count;

    assign w_full   = (r_count == COUNT_FULL);
    assign w_empty  = (r_count == '0);
    assign w_p_move = r_p_valid && (!r_o_valid || i_ready);
    assign o_ready  = !r_p_valid || w_p_move;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        w_ctl    = '0;
        n_count  = r_count;
        n_status = bdq_pkg::STATUS_DONE;
        case (i_func)
            bdq_pkg::FUNC_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = bdq_pkg::STATUS_FULL;
                end else begin
                    w_ctl.push_front = w_accept;
                    n_count          = r_count + CW'(1);
                end
            end
            bdq_pkg::FUNC_PUSH_BACK: begin
                if (w_full) begin
                    n_status = bdq_pkg::STATUS_FULL;
                end else begin
                    w_ctl.push_back = w_accept;
                    n_count         = r_count + CW'(1);
                end
            end
            bdq_pkg::FUNC_POP_FRONT: begin
                if (w_empty) begin
                    n_status = bdq_pkg::STATUS_EMPTY;
                end else begin
                    w_ctl.pop_front = w_accept;
                    n_count         = r_count - CW'(1);
                end
            end
            bdq_pkg::FUNC_POP_BACK: begin
                if (w_empty) begin
                    n_status = bdq_pkg::STATUS_EMPTY;
                end else begin
                    w_ctl.pop_back = w_accept;
                    n_count        = r_count - CW'(1);
                end
            end
            bdq_pkg::FUNC_SEARCH: begin
                w_ctl.search = w_accept;
            end
            default: begin
            end
        endcase
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [bdq_pkg::DATA_W-1:0] w_prev_data;
        logic                              w_prev_valid;
        logic signed [bdq_pkg::DATA_W-1:0] w_next_data;
        logic                              w_next_valid;

        if (g == 0) begin : g_first
            assign w_prev_data  = i_value;
            assign w_prev_valid = 1'b1;
        end else begin : g_mid
            assign w_prev_data  = w_data[g-1];
            assign w_prev_valid = w_valid[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_next_data  = i_value;
            assign w_next_valid = 1'b0;
        end else begin : g_inner
            assign w_next_data  = w_data[g+1];
            assign w_next_valid = w_valid[g+1];
        end

        bdq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_value      (i_value),
            .i_prev_data  (w_prev_data),
            .i_prev_valid (w_prev_valid),
            .i_next_data  (w_next_data),
            .i_next_valid (w_next_valid),
            .o_data       (w_data[g]),
            .o_valid      (w_valid[g]),
            .o_hit        (w_hit[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            if (w_accept) begin
                r_p_valid <= 1'b1;
            end else if (w_p_move) begin
                r_p_valid <= 1'b0;
            end
            if (w_p_move) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_p_search <= (i_func == bdq_pkg::FUNC_SEARCH);
            r_p_status <= n_status;
            r_p_count  <= n_count;
        end
        if (w_p_move) begin
            r_found   <= r_p_search && (|w_hit);
            r_status  <= r_p_status;
            r_o_count <= r_p_count;
        end
    end

    assign o_valid  = r_o_valid;
    assign o_found  = r_found;
    assign o_status = r_status;
    assign o_count  = r_o_count;

endmodule
